// ===== design/fully_assoc_lru_miss_classifier_defines.svh =====
// Assertion macros for the fully associative LRU miss classifier.
`ifndef FULLY_ASSOC_LRU_MISS_CLASSIFIER_DEFINES_SVH
`define FULLY_ASSOC_LRU_MISS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FALMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("falmc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define FALMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("falmc: next-cycle check failed");
`else
`define FALMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FALMC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/falmc_pkg.sv =====
// Package with widths, constants and the result type of the miss classifier.
`timescale 1ns / 1ps

package falmc_pkg;

    // Fixed field widths.
    localparam int ADDR_W      = 64;
    localparam int EVTAG_W     = 58;
    localparam int CNT_W       = 48;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 208;

    // Saturation value of the event counters.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One result; the last field sits in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0]   shadow_miss_total;
        logic [CNT_W-1:0]   real_miss_total;
        logic [CNT_W-1:0]   access_total;
        logic [EVTAG_W-1:0] evicted_tag;
        logic               evicted;
        logic               conflict_miss;
        logic               shadow_miss;
    } t_result;

endpackage

// ===== design/fully_assoc_lru_miss_classifier.sv =====
// Fully associative LRU shadow tag store that classifies real cache misses.
// A transaction accepted into the input register passes to the output register.
// Throughput: one transaction per cycle while m_axis_tready holds; all tags are compared
// and all ranks updated in parallel in the logic after the input register.
// Reset (synchronous, active low) empties the store and clears the counters.
`timescale 1ns / 1ps

`include "fully_assoc_lru_miss_classifier_defines.svh"

module fully_assoc_lru_miss_classifier #(
    parameter int ENTRIES     = 32,
    parameter int OFFSET_BITS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [63:0] address
    input  logic [falmc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: [0] real_cache_missed
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [0] shadow_miss, [1] conflict_miss, [2] evicted, [60:3] evicted_tag,
    // [108:61] access_total, [156:109] real_miss_total,
    // [204:157] shadow_miss_total, [207:205] zero
    output logic [falmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int TAG_W  = falmc_pkg::ADDR_W - OFFSET_BITS;
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(ENTRIES - 1);
    localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(ENTRIES);

    // Input register.
    logic              r_in_valid;
    logic [TAG_W-1:0]  r_tag;
    logic              r_real_miss;

    // Store state.
    logic [TAG_W-1:0]  r_tag_store [ENTRIES];
    logic [RANK_W-1:0] r_rank      [ENTRIES];
    logic [RANK_W-1:0] n_rank      [ENTRIES];
    logic [OCC_W-1:0]  r_occupied;
    logic [OCC_W-1:0]  n_occupied;

    // Counters.
    logic [falmc_pkg::CNT_W-1:0] r_access_cnt, n_access_cnt;
    logic [falmc_pkg::CNT_W-1:0] r_real_cnt, n_real_cnt;
    logic [falmc_pkg::CNT_W-1:0] r_shadow_cnt, n_shadow_cnt;

    // Output register.
    logic                r_out_valid;
    falmc_pkg::t_result  r_out;
    falmc_pkg::t_result  n_out;

    // Lookup signals.
    logic [ENTRIES-1:0]  w_valid_vec;
    logic [ENTRIES-1:0]  w_hit_vec;
    logic [ENTRIES-1:0]  w_victim_vec;
    logic [ENTRIES-1:0]  w_fill_vec;
    logic [ENTRIES-1:0]  w_write_vec;
    logic [RANK_W-1:0]   w_hit_rank;
    logic [TAG_W-1:0]    w_victim_tag;
    logic [falmc_pkg::ADDR_W-1:0] w_victim_ext;
    logic                w_hit;
    logic                w_miss;
    logic                w_full;
    logic                w_evict;
    logic                w_advance;

    // Handshake: the input stage moves on whenever the output register is free.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = falmc_pkg::OUT_TDATA_W'(r_out);

    // Parallel tag compare, victim search and per-entry select vectors.
    always_comb begin
        w_hit_rank   = '0;
        w_victim_tag = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_valid_vec[i]  = OCC_W'(i) < r_occupied;
            w_hit_vec[i]    = w_valid_vec[i] && (r_tag_store[i] == r_tag);
            w_victim_vec[i] = r_rank[i] == RANK_LAST;
            w_fill_vec[i]   = OCC_W'(i) == r_occupied;
            w_hit_rank      = w_hit_rank | (w_hit_vec[i] ? r_rank[i] : '0);
            w_victim_tag    = w_victim_tag | (w_victim_vec[i] ? r_tag_store[i] : '0);
        end
        w_hit        = |w_hit_vec;
        w_miss       = !w_hit;
        w_full       = r_occupied == OCC_FULL;
        w_evict      = w_miss && w_full;
        w_victim_ext = falmc_pkg::ADDR_W'(w_victim_tag);
        if (!w_miss) begin
            w_write_vec = '0;
        end else if (w_full) begin
            w_write_vec = w_victim_vec;
        end else begin
            w_write_vec = w_fill_vec;
        end
    end

    // Recency update: the touched entry becomes rank zero, more recent ones age.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_hit) begin
                if (w_hit_vec[i]) begin
                    n_rank[i] = '0;
                end else if (w_valid_vec[i] && (r_rank[i] < w_hit_rank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end else begin
                    n_rank[i] = r_rank[i];
                end
            end else if (w_write_vec[i]) begin
                n_rank[i] = '0;
            end else if (w_valid_vec[i]) begin
                n_rank[i] = r_rank[i] + 1'b1;
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
        n_occupied = (w_miss && !w_full) ? r_occupied + 1'b1 : r_occupied;
    end

    // Saturating counters and the result word.
    always_comb begin
        n_access_cnt = (r_access_cnt == falmc_pkg::CNT_MAX) ? r_access_cnt
                                                             : r_access_cnt + 1'b1;
        n_real_cnt   = (r_real_miss && (r_real_cnt != falmc_pkg::CNT_MAX))
                       ? r_real_cnt + 1'b1 : r_real_cnt;
        n_shadow_cnt = (w_miss && (r_shadow_cnt != falmc_pkg::CNT_MAX))
                       ? r_shadow_cnt + 1'b1 : r_shadow_cnt;

        n_out.shadow_miss       = w_miss;
        n_out.conflict_miss     = r_real_miss && w_hit;
        n_out.evicted           = w_evict;
        n_out.evicted_tag       = w_evict ? w_victim_ext[falmc_pkg::EVTAG_W-1:0] : '0;
        n_out.access_total      = n_access_cnt;
        n_out.real_miss_total   = n_real_cnt;
        n_out.shadow_miss_total = n_shadow_cnt;
    end

    // Control state, ranks and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_occupied   <= '0;
            r_access_cnt <= '0;
            r_real_cnt   <= '0;
            r_shadow_cnt <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_occupied   <= n_occupied;
                r_access_cnt <= n_access_cnt;
                r_real_cnt   <= n_real_cnt;
                r_shadow_cnt <= n_shadow_cnt;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // Payload registers and the tag store.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_tag       <= s_axis_tdata[falmc_pkg::ADDR_W-1:OFFSET_BITS];
            r_real_miss <= s_axis_tuser[0];
        end
        if (w_advance) begin
            r_out <= n_out;
            for (int i = 0; i < ENTRIES; i++) begin
                if (w_write_vec[i]) begin
                    r_tag_store[i] <= r_tag;
                end
            end
        end
    end

    // Checks on the store logic.
    `FALMC_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occupied <= OCC_FULL)
    `FALMC_ASSERT_IMP(a_tag_unique, i_clk, i_rst_n, r_in_valid, $onehot0(w_hit_vec))
    `FALMC_ASSERT_IMP(a_evict_full, i_clk, i_rst_n, w_advance && w_evict, $onehot(w_victim_vec))
    `FALMC_ASSERT_NXT(a_fill_grow, i_clk, i_rst_n, w_advance && w_miss && !w_full, r_occupied == OCC_W'($past(r_occupied) + 1'b1))
    `FALMC_ASSERT_IMP(a_out_excl, i_clk, i_rst_n, m_axis_tvalid && r_out.conflict_miss, !r_out.shadow_miss && !r_out.evicted)

endmodule
